FILE: hdl/palette_lookup_8bpp_to_rgb565_unit_assert.svh
// Assertion macros for the palette lookup RTL.
`ifndef PALETTE_LOOKUP_8BPP_TO_RGB565_UNIT_ASSERT_SVH
`define PALETTE_LOOKUP_8BPP_TO_RGB565_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/plk_pkg.sv
// Shared types, constants and helpers of the palette lookup unit.
package plk_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PIXELS_PER_ITEM = 4;

    localparam int INDEX_W      = 8;
    localparam int COMP_W       = 6;
    localparam int COLOR_W      = 16;
    localparam int COLOR_FIELDS = 4;
    localparam int LANES        = (PIXELS_PER_ITEM > COLOR_FIELDS) ? COLOR_FIELDS
                                                                   : PIXELS_PER_ITEM;
    localparam int ADDR_W       = $clog2(PALETTE_ENTRIES);
    localparam int TDATA_IN_W   = 64;
    localparam int TDATA_OUT_W  = COLOR_FIELDS * COLOR_W;

    // Bit positions of the input word fields.
    localparam int ENTRY_LSB = COLOR_FIELDS * INDEX_W;
    localparam int RED_LSB   = ENTRY_LSB + INDEX_W;
    localparam int GREEN_LSB = RED_LSB + COMP_W;
    localparam int BLUE_LSB  = GREEN_LSB + COMP_W;

    localparam logic [INDEX_W:0] ENTRY_LIMIT = (INDEX_W + 1)'(PALETTE_ENTRIES);

    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [COMP_W-1:0]  comp_t;
    typedef logic [COLOR_W-1:0] color_t;

    typedef enum logic
    {
        OP_WRITE   = 1'b0,
        OP_CONVERT = 1'b1
    } opcode_t;

    // Control of the lookup stage as seen by the merge stage.
    typedef struct packed
    {
        logic valid;
        logic last;
    } stage_t;

    // RGB565 packing: red and blue lose their least significant bit.
    function automatic color_t pack_rgb565(comp_t red, comp_t green, comp_t blue);
        return {red[COMP_W-1:1], green, blue[COMP_W-1:1]};
    endfunction

endpackage

FILE: hdl/plk_lane.sv
// One lookup lane: a private copy of the palette with a registered read port.
module plk_lane
(
    input  logic            clk,
    input  logic            wr_en,
    input  plk_pkg::index_t wr_index,
    input  plk_pkg::color_t wr_color,
    input  logic            rd_en,
    input  plk_pkg::index_t rd_index,
    output plk_pkg::color_t rd_color
);
    import plk_pkg::*;

    color_t mem [PALETTE_ENTRIES];
    color_t rd_data_reg;
    logic   rd_hit_reg;
    logic   wr_hit;
    logic   rd_hit;

    assign wr_hit = {1'b0, wr_index} < ENTRY_LIMIT;
    assign rd_hit = {1'b0, rd_index} < ENTRY_LIMIT;

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_hit)
        begin
            mem[wr_index[ADDR_W-1:0]] <= wr_color;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_index[ADDR_W-1:0]];
            rd_hit_reg  <= rd_hit;
        end
    end

    // Indices past the end of the palette read as black.
    assign rd_color = rd_hit_reg ? rd_data_reg : '0;

endmodule

FILE: hdl/plk_merge.sv
// Merge stage: gathers the lane colors into one output word register.
module plk_merge
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  plk_pkg::stage_t                    stage,
    input  plk_pkg::color_t                    lane_color [plk_pkg::LANES],
    output logic                               ready,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [plk_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast
);
    import plk_pkg::*;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [TDATA_OUT_W-1:0] out_data_reg;
    logic [TDATA_OUT_W-1:0] out_data_next;
    logic                   out_last_reg;
    logic                   load;

    assign ready = !out_valid_reg || m_axis_tready;
    assign load  = stage.valid && ready;

    always_comb
    begin
        out_data_next = '0;
        for (int j = 0; j < LANES; j++)
        begin
            out_data_next[j*COLOR_W +: COLOR_W] = lane_color[j];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ready)
        begin
            out_valid_next = stage.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= stage.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: hdl/palette_lookup_8bpp_to_rgb565_unit.sv
// Top level of the 8bpp palette to RGB565 lookup unit.
//
// This unit converts groups of four 8-bit pixel indices into four RGB565
// colors through a 256-entry palette, and it accepts one word per clock
// cycle for as long as the output side keeps taking words. The input tuser
// bit selects the kind of word: a write word (tuser low) stores one palette
// entry built from 6-bit red, green and blue, with red and blue dropping
// their least significant bit, and produces no output word; a convert word
// (tuser high) looks up its four indices and produces exactly one output
// word carrying the four colors, the first index in the lowest bits, with
// the input tlast copied to the output tlast. Each of the four lookup lanes
// owns a private copy of the palette, so every write goes to all copies and
// each copy serves a single read per cycle. A convert word reaches the
// output through the registered palette read and then the output
// register in the merge stage. A palette entry must be written before any
// convert word reads it; a write is visible to a convert word accepted in
// the very next cycle. The palette has no reset and needs no clearing pass.
`include "palette_lookup_8bpp_to_rgb565_unit_assert.svh"

module palette_lookup_8bpp_to_rgb565_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pixel_index_0 [7:0], pixel_index_1 [15:8], pixel_index_2 [23:16],
    // pixel_index_3 [31:24], entry_index [39:32], red [45:40],
    // green [51:46], blue [57:52], zero [63:58]
    input  logic [plk_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
    // opcode [0]
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // color_0 [15:0], color_1 [31:16], color_2 [47:32], color_3 [63:48]
    output logic [plk_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast
);
    import plk_pkg::*;

    logic    take;
    logic    wr_en;
    opcode_t opcode;
    color_t  wr_color;
    index_t  wr_index;
    logic    merge_ready;
    stage_t  stage;
    color_t  lane_color [LANES];

    // Lookup stage control; the lane read registers hold the matching data.
    logic s1_valid_reg;
    logic s1_valid_next;
    logic s1_last_reg;
    logic s1_last_next;

    assign opcode        = opcode_t'(s_axis_tuser);
    assign s_axis_tready = !s1_valid_reg || merge_ready;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign wr_en         = take && (opcode == OP_WRITE);
    assign wr_index      = s_axis_tdata[ENTRY_LSB +: INDEX_W];
    assign wr_color      = pack_rgb565(s_axis_tdata[RED_LSB +: COMP_W],
                                       s_axis_tdata[GREEN_LSB +: COMP_W],
                                       s_axis_tdata[BLUE_LSB +: COMP_W]);

    // The stage reloads whenever it can accept; write words leave it empty.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_last_next  = s1_last_reg;
        if (s_axis_tready)
        begin
            s1_valid_next = take && (opcode == OP_CONVERT);
            s1_last_next  = s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg <= s1_last_next;
    end

    // One lane per pixel of the group, each with its own palette copy.
    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        plk_lane u_lane
        (
            .clk      (clk),
            .wr_en    (wr_en),
            .wr_index (wr_index),
            .wr_color (wr_color),
            .rd_en    (s_axis_tready),
            .rd_index (s_axis_tdata[j*INDEX_W +: INDEX_W]),
            .rd_color (lane_color[j])
        );
    end

    assign stage.valid = s1_valid_reg;
    assign stage.last  = s1_last_reg;

    plk_merge u_merge
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .stage         (stage),
        .lane_color    (lane_color),
        .ready         (merge_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A write word never creates a pending lookup.
    `PLK_ASSERT_NEXT(a_write_no_result, clk, rst_n, wr_en, !s1_valid_reg, "write word produced a lookup")
    // A convert word always enters the lookup stage.
    `PLK_ASSERT_NEXT(a_convert_enters, clk, rst_n, take && (opcode == OP_CONVERT), s1_valid_reg, "convert word was lost")
    // A lookup blocked by a full output register keeps its word and its mark.
    `PLK_ASSERT_NEXT(a_stage_holds, clk, rst_n, s1_valid_reg && !merge_ready, s1_valid_reg && $stable(s1_last_reg), "stalled lookup changed")
    // The output side only fills from a pending lookup.
    `PLK_ASSERT_NEXT(a_out_from_stage, clk, rst_n, !m_axis_tvalid && !s1_valid_reg, !m_axis_tvalid, "output filled without a lookup")

endmodule
